// File: rtl/aarm_pkg.sv
// Shared types, constants and the CORDIC angle table of the axis-angle block.
// Depends on nothing; every other file of the block imports it.
package aarm_pkg;

    // Q1.14 one, and the phase conversion: round(2^32 / (2*pi * 2^12)).
    localparam int ONE_Q14      = 16384;
    localparam int PHASE_SCALE  = 166886;
    localparam int PHASE_ROUND  = 32768;

    // CORDIC start value (gain compensation) in Q1.30 and its step count.
    localparam int CORDIC_GAIN  = 652032874;
    localparam int CORDIC_STEPS = 16;

    // Square root of len2 * 2^28: 30 result bits, the low 14 digit pairs are zero.
    localparam int SQRT_STEPS   = 30;
    localparam int SQRT_PAD     = 14;
    localparam int ROOT_W       = 30;

    // The unit components are at most 2^14, so 15 quotient bits suffice.
    localparam int DIV_STEPS    = 15;

    // Queue between the front and the back.
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;

    // One input beat.
    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] angle;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic               axis_zero;
    } t_out_item;

    // Classified item as it leaves the front.
    typedef struct packed {
        logic             zero;
        logic [31:0]      len2;
        logic [15:0]      phase;
        logic [2:0]       neg;
        logic [2:0][15:0] mag;
    } t_fe_item;

    // Item with its unit axis.
    typedef struct packed {
        logic               zero;
        logic [15:0]        phase;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
    } t_nu_item;

    // Item with unit axis, cosine and sine.
    typedef struct packed {
        logic               zero;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic signed [15:0] c;
        logic signed [15:0] s;
    } t_tr_item;

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:    v = 32'h20000000;
            4'd1:    v = 32'h12E4051E;
            4'd2:    v = 32'h09FB385B;
            4'd3:    v = 32'h051111D4;
            4'd4:    v = 32'h028B0D43;
            4'd5:    v = 32'h0145D7E1;
            4'd6:    v = 32'h00A2F61E;
            4'd7:    v = 32'h00517C55;
            4'd8:    v = 32'h0028BE53;
            4'd9:    v = 32'h00145F2F;
            4'd10:   v = 32'h000A2F98;
            4'd11:   v = 32'h000517CC;
            4'd12:   v = 32'h00028BE6;
            4'd13:   v = 32'h000145F3;
            4'd14:   v = 32'h0000A2FA;
            default: v = 32'h0000517D;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/aarm_front.sv
// Front of the axis-angle block: accepts beats, squares the axis, converts the angle
// to a turn phase and flags a zero axis. Depends on aarm_pkg.
module aarm_front import aarm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_valid,
    output t_fe_item o_item
);

    logic               r_v1, r_v2, r_v3;
    t_in_item           r_in1;
    logic [30:0]        r_sq [3];
    logic [15:0]        r_phase2;
    logic [2:0]         r_neg2;
    logic [2:0][15:0]   r_mag2;
    t_fe_item           r_item3;

    logic               en;
    logic signed [15:0] w_ax [3];
    logic signed [31:0] n_sq [3];
    logic signed [34:0] n_prod;
    logic [31:0]        n_len2;

    // The whole front holds while the queue is full.
    assign en = !i_full;

    assign w_ax[0] = r_in1.axis_x;
    assign w_ax[1] = r_in1.axis_y;
    assign w_ax[2] = r_in1.axis_z;

    // Squares of the axis components and the rounded phase product.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_sq[l] = 32'(w_ax[l]) * 32'(w_ax[l]);
        end
        n_prod = 35'(r_in1.angle) * 35'(PHASE_SCALE) + 35'(PHASE_ROUND);
    end

    // Squared length of the axis.
    assign n_len2 = 32'(r_sq[0]) + 32'(r_sq[1]) + 32'(r_sq[2]);

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in1 <= i_item;
            for (int l = 0; l < 3; l++) begin
                r_sq[l]   <= n_sq[l][30:0];
                r_neg2[l] <= w_ax[l][15];
                r_mag2[l] <= w_ax[l][15] ? 16'(-w_ax[l]) : 16'(w_ax[l]);
            end
            r_phase2      <= n_prod[31:16];
            r_item3.zero  <= (n_len2 == 32'd0);
            r_item3.len2  <= n_len2;
            r_item3.phase <= r_phase2;
            r_item3.neg   <= r_neg2;
            r_item3.mag   <= r_mag2;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_item3;

endmodule

// File: rtl/aarm_queue.sv
// Short queue between the front and the back of the axis-angle block.
// Depends on aarm_pkg; the back takes one beat every cycle that the queue holds one.
module aarm_queue import aarm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_fe_item i_item,
    output logic     o_full,
    output logic     o_valid,
    output t_fe_item o_item
);

    t_fe_item        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    logic pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid;
    assign o_item  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// File: rtl/aarm_norm.sv
// Axis normalizer: a pipelined digit-by-digit square root of len2 * 2^28 followed
// by three pipelined restoring dividers. Depends on aarm_pkg.
module aarm_norm import aarm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_fe_item i_item,
    output logic     o_valid,
    output t_nu_item o_item
);

    // Square root stage registers.
    logic              r_sv    [SQRT_STEPS];
    t_fe_item          r_sit   [SQRT_STEPS];
    logic [33:0]       r_srem  [SQRT_STEPS];
    logic [ROOT_W-1:0] r_sroot [SQRT_STEPS];

    // Divider stage registers, one lane per axis component.
    logic              r_dv    [DIV_STEPS];
    t_fe_item          r_dit   [DIV_STEPS];
    logic [ROOT_W-1:0] r_droot [DIV_STEPS];
    logic [2:0][29:0]  r_drem  [DIV_STEPS];
    logic [2:0][14:0]  r_dlo   [DIV_STEPS];
    logic [2:0][14:0]  r_dq    [DIV_STEPS];

    logic     r_ov;
    t_nu_item r_oit;

    genvar k;

    // One root bit per stage.
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam int I = SQRT_STEPS - 1 - k;
        logic              w_v;
        t_fe_item          w_it;
        logic [33:0]       w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [1:0]        w_dig;
        logic [33:0]       n_sh, n_trial;

        if (k == 0) begin : g_in
            assign w_v    = i_valid;
            assign w_it   = i_item;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_chain
            assign w_v    = r_sv[k-1];
            assign w_it   = r_sit[k-1];
            assign w_rem  = r_srem[k-1];
            assign w_root = r_sroot[k-1];
        end

        if (I >= SQRT_PAD) begin : g_dig
            assign w_dig = w_it.len2[2*(I-SQRT_PAD) +: 2];
        end else begin : g_pad
            assign w_dig = 2'b00;
        end

        assign n_sh    = {w_rem[31:0], w_dig};
        assign n_trial = {2'b00, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else begin
                r_sv[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sit[k] <= w_it;
            if (n_sh >= n_trial) begin
                r_srem[k]  <= n_sh - n_trial;
                r_sroot[k] <= {w_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_srem[k]  <= n_sh;
                r_sroot[k] <= {w_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // One quotient bit per stage in each lane.
    for (k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int J = DIV_STEPS - 1 - k;
        logic              w_v;
        t_fe_item          w_it;
        logic [ROOT_W-1:0] w_root;
        logic [2:0][29:0]  w_rem;
        logic [2:0][14:0]  w_lo;
        logic [2:0][14:0]  w_q;
        logic [2:0][30:0]  n_sh;

        if (k == 0) begin : g_in
            logic [2:0][43:0] n_num;
            assign w_v    = r_sv[SQRT_STEPS-1];
            assign w_it   = r_sit[SQRT_STEPS-1];
            assign w_root = r_sroot[SQRT_STEPS-1];
            // Numerator mag * 2^28 plus half the divisor, split into head and tail.
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    n_num[l] = {w_it.mag[l], 28'd0} + {15'd0, w_root[ROOT_W-1:1]};
                    w_rem[l] = {1'b0, n_num[l][43:15]};
                    w_lo[l]  = n_num[l][14:0];
                end
            end
            assign w_q = '0;
        end else begin : g_chain
            assign w_v    = r_dv[k-1];
            assign w_it   = r_dit[k-1];
            assign w_root = r_droot[k-1];
            assign w_rem  = r_drem[k-1];
            assign w_lo   = r_dlo[k-1];
            assign w_q    = r_dq[k-1];
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_sh[l] = {w_rem[l], w_lo[l][J]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else begin
                r_dv[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dit[k]   <= w_it;
            r_droot[k] <= w_root;
            r_dlo[k]   <= w_lo;
            for (int l = 0; l < 3; l++) begin
                if (n_sh[l] >= {1'b0, w_root}) begin
                    r_drem[k][l] <= 30'(n_sh[l] - {1'b0, w_root});
                    r_dq[k][l]   <= {w_q[l][13:0], 1'b1};
                end else begin
                    r_drem[k][l] <= n_sh[l][29:0];
                    r_dq[k][l]   <= {w_q[l][13:0], 1'b0};
                end
            end
        end
    end

    // Clamp to one and restore the sign of each component.
    logic signed [15:0] n_u [3];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic signed [15:0] q;
            q = (r_dq[DIV_STEPS-1][l] > 15'(ONE_Q14)) ? 16'(ONE_Q14)
                                                      : 16'(r_dq[DIV_STEPS-1][l]);
            n_u[l] = r_dit[DIV_STEPS-1].neg[l] ? -q : q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_dv[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_oit.zero  <= r_dit[DIV_STEPS-1].zero;
        r_oit.phase <= r_dit[DIV_STEPS-1].phase;
        r_oit.ux    <= n_u[0];
        r_oit.uy    <= n_u[1];
        r_oit.uz    <= n_u[2];
    end

    assign o_valid = r_ov;
    assign o_item  = r_oit;

endmodule

// File: rtl/aarm_trig.sv
// Sine and cosine of the turn phase: a 16-stage CORDIC on Q1.30 values, then
// quadrant folding and rounding to Q1.14. Depends on aarm_pkg.
module aarm_trig import aarm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_nu_item i_item,
    output logic     o_valid,
    output t_tr_item o_item
);

    logic               r_v  [CORDIC_STEPS];
    t_nu_item           r_it [CORDIC_STEPS];
    logic signed [33:0] r_cx [CORDIC_STEPS];
    logic signed [33:0] r_cy [CORDIC_STEPS];
    logic signed [31:0] r_z  [CORDIC_STEPS];

    logic     r_ov;
    t_tr_item r_oit;

    // Round a Q1.30 value to Q1.14 and clamp to plus or minus one.
    function automatic logic signed [15:0] to_q14(input logic signed [34:0] v);
        logic signed [34:0] w;
        logic signed [18:0] r;
        logic signed [15:0] res;
        w = v + 35'sd32768;
        r = $signed(w[34:16]);
        if (r > 19'sd16384) begin
            res = 16'sd16384;
        end else if (r < -19'sd16384) begin
            res = -16'sd16384;
        end else begin
            res = 16'(r);
        end
        return res;
    endfunction

    genvar k;

    // One micro-rotation per stage.
    for (k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        logic               w_v;
        t_nu_item           w_it;
        logic signed [33:0] w_cx, w_cy;
        logic signed [31:0] w_z;
        logic signed [33:0] n_dx, n_dy;
        logic signed [31:0] n_at;

        if (k == 0) begin : g_in
            assign w_v  = i_valid;
            assign w_it = i_item;
            assign w_cx = 34'(CORDIC_GAIN);
            assign w_cy = '0;
            assign w_z  = $signed({2'b00, i_item.phase[13:0], 16'd0});
        end else begin : g_chain
            assign w_v  = r_v[k-1];
            assign w_it = r_it[k-1];
            assign w_cx = r_cx[k-1];
            assign w_cy = r_cy[k-1];
            assign w_z  = r_z[k-1];
        end

        assign n_dx = w_cy >>> k;
        assign n_dy = w_cx >>> k;
        assign n_at = $signed(atan_turn(4'(k)));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_it[k] <= w_it;
            if (!w_z[31]) begin
                r_cx[k] <= w_cx - n_dx;
                r_cy[k] <= w_cy + n_dy;
                r_z[k]  <= w_z - n_at;
            end else begin
                r_cx[k] <= w_cx + n_dx;
                r_cy[k] <= w_cy - n_dy;
                r_z[k]  <= w_z + n_at;
            end
        end
    end

    // Fold the quadrant back in by swapping and negating.
    logic signed [34:0] n_c30, n_s30, w_x, w_y;
    assign w_x = 35'(r_cx[CORDIC_STEPS-1]);
    assign w_y = 35'(r_cy[CORDIC_STEPS-1]);
    always_comb begin
        case (r_it[CORDIC_STEPS-1].phase[15:14])
            2'd0: begin
                n_c30 = w_x;
                n_s30 = w_y;
            end
            2'd1: begin
                n_c30 = -w_y;
                n_s30 = w_x;
            end
            2'd2: begin
                n_c30 = -w_x;
                n_s30 = -w_y;
            end
            default: begin
                n_c30 = w_y;
                n_s30 = -w_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_oit.zero <= r_it[CORDIC_STEPS-1].zero;
        r_oit.ux   <= r_it[CORDIC_STEPS-1].ux;
        r_oit.uy   <= r_it[CORDIC_STEPS-1].uy;
        r_oit.uz   <= r_it[CORDIC_STEPS-1].uz;
        r_oit.c    <= to_q14(n_c30);
        r_oit.s    <= to_q14(n_s30);
    end

    assign o_valid = r_ov;
    assign o_item  = r_oit;

endmodule

// File: rtl/aarm_matrix.sv
// Rodrigues matrix assembly in three stages: t*u and s*u, then t*ui*uj, then the
// nine sums with rounding and saturation. Depends on aarm_pkg.
module aarm_matrix import aarm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_tr_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    logic               r_v1, r_v2, r_v3;
    logic               r_zero1, r_zero2;
    logic signed [15:0] r_c1, r_c2;
    logic signed [15:0] r_u1 [3];
    logic signed [31:0] r_tu1 [3];
    logic signed [31:0] r_su1 [3];
    logic signed [31:0] r_su2 [3];
    logic signed [47:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
    t_out_item          r_res;

    logic signed [17:0] n_t;
    logic signed [15:0] w_u [3];
    logic signed [47:0] n_cf, n_sx, n_sy, n_sz;

    // Round a 42-fraction-bit sum to Q1.14 and saturate to 16 bits.
    function automatic logic signed [15:0] entry(input logic signed [47:0] acc);
        logic signed [47:0] w;
        logic signed [19:0] r;
        logic signed [15:0] res;
        w = acc + 48'sd134217728;
        r = $signed(w[47:28]);
        if (r > 20'sd32767) begin
            res = 16'sd32767;
        end else if (r < -20'sd32768) begin
            res = -16'sd32768;
        end else begin
            res = 16'(r);
        end
        return res;
    endfunction

    assign w_u[0] = i_item.ux;
    assign w_u[1] = i_item.uy;
    assign w_u[2] = i_item.uz;
    assign n_t    = 18'(ONE_Q14) - 18'(i_item.c);

    assign n_cf = 48'(r_c2) <<< 28;
    assign n_sx = 48'(r_su2[0]) <<< 14;
    assign n_sy = 48'(r_su2[1]) <<< 14;
    assign n_sz = 48'(r_su2[2]) <<< 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // First products: t*u and s*u.
    always_ff @(posedge i_clk) begin
        r_zero1 <= i_item.zero;
        r_c1    <= i_item.c;
        for (int l = 0; l < 3; l++) begin
            r_u1[l]  <= w_u[l];
            r_tu1[l] <= 32'(n_t) * 32'(w_u[l]);
            r_su1[l] <= 32'(i_item.s) * 32'(w_u[l]);
        end
    end

    // Second products: t*ui*uj.
    always_ff @(posedge i_clk) begin
        r_zero2 <= r_zero1;
        r_c2    <= r_c1;
        r_su2   <= r_su1;
        r_xx    <= 48'(r_tu1[0]) * 48'(r_u1[0]);
        r_yy    <= 48'(r_tu1[1]) * 48'(r_u1[1]);
        r_zz    <= 48'(r_tu1[2]) * 48'(r_u1[2]);
        r_xy    <= 48'(r_tu1[0]) * 48'(r_u1[1]);
        r_xz    <= 48'(r_tu1[0]) * 48'(r_u1[2]);
        r_yz    <= 48'(r_tu1[1]) * 48'(r_u1[2]);
    end

    // Sums, rounding and the identity for a zero axis.
    always_ff @(posedge i_clk) begin
        if (r_zero2) begin
            r_res.m00 <= 16'sd16384;
            r_res.m01 <= '0;
            r_res.m02 <= '0;
            r_res.m10 <= '0;
            r_res.m11 <= 16'sd16384;
            r_res.m12 <= '0;
            r_res.m20 <= '0;
            r_res.m21 <= '0;
            r_res.m22 <= 16'sd16384;
        end else begin
            r_res.m00 <= entry(n_cf + r_xx);
            r_res.m01 <= entry(r_xy - n_sz);
            r_res.m02 <= entry(r_xz + n_sy);
            r_res.m10 <= entry(r_xy + n_sz);
            r_res.m11 <= entry(n_cf + r_yy);
            r_res.m12 <= entry(r_yz - n_sx);
            r_res.m20 <= entry(r_xz - n_sy);
            r_res.m21 <= entry(r_yz + n_sx);
            r_res.m22 <= entry(n_cf + r_zz);
        end
        r_res.axis_zero <= r_zero2;
    end

    assign o_valid  = r_v3;
    assign o_result = r_res;

endmodule

// File: rtl/axis_angle_to_rotation_matrix.sv
// Top level of the axis-angle to rotation matrix block.
// Depends on aarm_pkg, aarm_front, aarm_queue, aarm_norm, aarm_trig and aarm_matrix.
//
// Usage: drive i_item (axis x, y, z in Q1.14 and angle in Q3.12 radians) and raise
// start; the beat is taken at a rising edge where start is high and busy is low.
// Each beat yields one result: the nine row-major matrix entries in Q1.14 and the
// axis_zero flag, shown on o_result for exactly one cycle with o_valid high.
// Throughput is one beat per cycle: the front, the normalizer (a 30-stage square
// root and 15-stage dividers), the 16-stage CORDIC and the matrix stages are all
// fully pipelined, so busy stays low in normal use. busy rises only if the queue
// between front and back fills, which the back prevents by draining it every cycle.
// A zero axis returns the identity matrix with axis_zero set.
// Reset (synchronous, active low) empties every stage and the queue; no result
// appears until a new beat is taken. The receiver cannot stall: results are not held.
module axis_angle_to_rotation_matrix import aarm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out_item o_result
);

    logic     fe_valid, q_full, q_valid, nu_valid, tr_valid, push;
    t_fe_item fe_item, q_item;
    t_nu_item nu_item;
    t_tr_item tr_item;

    assign busy = q_full;
    assign push = fe_valid && !q_full;

    // Accept and classify.
    aarm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_valid (fe_valid),
        .o_item  (fe_item)
    );

    // Decoupling queue.
    aarm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fe_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Unit axis.
    aarm_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_valid (nu_valid),
        .o_item  (nu_item)
    );

    // Sine and cosine.
    aarm_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nu_valid),
        .i_item  (nu_item),
        .o_valid (tr_valid),
        .o_item  (tr_item)
    );

    // Matrix entries.
    aarm_matrix u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (tr_valid),
        .i_item   (tr_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
